/* design/alusf_pkg.sv */
// Shared types and operation codes for the 6502 binary-mode ALU pipeline.
package alusf_pkg;

    typedef enum logic [4:0] {
        OP_ADC  = 5'd0,
        OP_SBC  = 5'd1,
        OP_AND  = 5'd2,
        OP_OR   = 5'd3,
        OP_XOR  = 5'd4,
        OP_CMP  = 5'd5,
        OP_INCM = 5'd6,
        OP_DECM = 5'd7,
        OP_INCR = 5'd8,
        OP_DECR = 5'd9,
        OP_ASL  = 5'd10,
        OP_ROL  = 5'd11,
        OP_LSR  = 5'd12,
        OP_ROR  = 5'd13,
        OP_BIT  = 5'd14,
        OP_SLO  = 5'd15,
        OP_RLA  = 5'd16,
        OP_SRE  = 5'd17,
        OP_RRA  = 5'd18,
        OP_DCP  = 5'd19,
        OP_ISC  = 5'd20,
        OP_ANC  = 5'd21,
        OP_ALR  = 5'd22,
        OP_PASS = 5'd23
    } op_t;

    localparam int FLAG_C_BIT = 0;
    localparam int FLAG_Z_BIT = 1;
    localparam int FLAG_V_BIT = 6;
    localparam int FLAG_N_BIT = 7;

    typedef struct packed {
        op_t        op;
        logic [7:0] reg_value;
        logic [7:0] mem_value;
        logic [7:0] status_in;
    } in_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] reg_value;
        logic [7:0] mem_value;
        logic [7:0] status_in;
        logic [7:0] mem_mod;
        logic       carry;
    } prep_t;

    typedef struct packed {
        logic upd_nz;
        logic upd_c;
        logic upd_v;
        logic n_from_mem;
        logic n_alt;
        logic c_new;
        logic v_new;
    } flag_ctl_t;

    typedef struct packed {
        logic [7:0] reg_result;
        logic [7:0] mem_result;
        logic [7:0] status_in;
        logic [7:0] nz_value;
        flag_ctl_t  ctl;
    } exec_t;

    typedef struct packed {
        logic [7:0] reg_result;
        logic [7:0] mem_result;
        logic [7:0] status_out;
    } out_item_t;

endpackage

/* design/alusf_prep.sv */
// Stage 1: memory operand modify (inc, dec, shift, rotate) and carry-in selection.
module alusf_prep
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  alusf_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output alusf_pkg::prep_t  out_data
);

    logic             valid_reg;
    logic             valid_next;
    alusf_pkg::prep_t data_reg;
    alusf_pkg::prep_t data_next;
    logic [7:0]       m;
    logic             cin;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign m         = in_data.mem_value;
    assign cin       = in_data.status_in[alusf_pkg::FLAG_C_BIT];

    always_comb
    begin
        data_next.op        = in_data.op;
        data_next.reg_value = in_data.reg_value;
        data_next.mem_value = in_data.mem_value;
        data_next.status_in = in_data.status_in;
        data_next.mem_mod   = m;
        data_next.carry     = cin;
        case (in_data.op)
            alusf_pkg::OP_INCM, alusf_pkg::OP_ISC:
            begin
                data_next.mem_mod = m + 8'd1;
            end
            alusf_pkg::OP_DECM, alusf_pkg::OP_DCP:
            begin
                data_next.mem_mod = m - 8'd1;
            end
            alusf_pkg::OP_ASL, alusf_pkg::OP_SLO:
            begin
                data_next.mem_mod = {m[6:0], 1'b0};
                data_next.carry   = m[7];
            end
            alusf_pkg::OP_ROL, alusf_pkg::OP_RLA:
            begin
                data_next.mem_mod = {m[6:0], cin};
                data_next.carry   = m[7];
            end
            alusf_pkg::OP_LSR, alusf_pkg::OP_SRE:
            begin
                data_next.mem_mod = {1'b0, m[7:1]};
                data_next.carry   = m[0];
            end
            alusf_pkg::OP_ROR, alusf_pkg::OP_RRA:
            begin
                data_next.mem_mod = {cin, m[7:1]};
                data_next.carry   = m[0];
            end
            default:
            begin
                data_next.mem_mod = m;
            end
        endcase
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/alusf_exec.sv */
// Stage 2: shared 8-bit adder, logic ops and per-operation flag selection.
module alusf_exec
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  alusf_pkg::prep_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output alusf_pkg::exec_t out_data
);

    logic             valid_reg;
    logic             valid_next;
    alusf_pkg::exec_t data_reg;
    alusf_pkg::exec_t data_next;
    logic [7:0]       a;
    logic [7:0]       m;
    logic [7:0]       rm;
    logic [7:0]       y;
    logic             ci;
    logic [8:0]       sum;
    logic [7:0]       res;
    logic             ov;
    logic [7:0]       am;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign a         = in_data.reg_value;
    assign m         = in_data.mem_value;
    assign rm        = in_data.mem_mod;
    assign am        = a & m;

    always_comb
    begin
        y  = m;
        ci = in_data.carry;
        case (in_data.op)
            alusf_pkg::OP_SBC:
            begin
                y = ~m;
            end
            alusf_pkg::OP_CMP:
            begin
                y  = ~m;
                ci = 1'b1;
            end
            alusf_pkg::OP_INCR:
            begin
                y  = 8'h00;
                ci = 1'b1;
            end
            alusf_pkg::OP_DECR:
            begin
                y  = 8'hFF;
                ci = 1'b0;
            end
            alusf_pkg::OP_RRA:
            begin
                y = rm;
            end
            alusf_pkg::OP_DCP:
            begin
                y  = ~rm;
                ci = 1'b1;
            end
            alusf_pkg::OP_ISC:
            begin
                y = ~rm;
            end
            default:
            begin
                y = m;
            end
        endcase
    end

    assign sum = {1'b0, a} + {1'b0, y} + {8'd0, ci};
    assign res = sum[7:0];
    assign ov  = ((a[7] ^ res[7]) & (y[7] ^ res[7]));

    always_comb
    begin
        data_next.reg_result     = a;
        data_next.mem_result     = rm;
        data_next.status_in      = in_data.status_in;
        data_next.nz_value       = a;
        data_next.ctl.upd_nz     = 1'b0;
        data_next.ctl.upd_c      = 1'b0;
        data_next.ctl.upd_v      = 1'b0;
        data_next.ctl.n_from_mem = 1'b0;
        data_next.ctl.n_alt      = m[7];
        data_next.ctl.c_new      = in_data.carry;
        data_next.ctl.v_new      = ov;
        case (in_data.op)
            alusf_pkg::OP_ADC, alusf_pkg::OP_SBC, alusf_pkg::OP_RRA, alusf_pkg::OP_ISC:
            begin
                data_next.reg_result = res;
                data_next.nz_value   = res;
                data_next.ctl.c_new  = sum[8];
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
                data_next.ctl.upd_v  = 1'b1;
            end
            alusf_pkg::OP_AND:
            begin
                data_next.reg_result = am;
                data_next.nz_value   = am;
                data_next.ctl.upd_nz = 1'b1;
            end
            alusf_pkg::OP_OR:
            begin
                data_next.reg_result = a | m;
                data_next.nz_value   = a | m;
                data_next.ctl.upd_nz = 1'b1;
            end
            alusf_pkg::OP_XOR:
            begin
                data_next.reg_result = a ^ m;
                data_next.nz_value   = a ^ m;
                data_next.ctl.upd_nz = 1'b1;
            end
            alusf_pkg::OP_CMP, alusf_pkg::OP_DCP:
            begin
                data_next.nz_value   = res;
                data_next.ctl.c_new  = sum[8];
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
            end
            alusf_pkg::OP_INCM, alusf_pkg::OP_DECM:
            begin
                data_next.nz_value   = rm;
                data_next.ctl.upd_nz = 1'b1;
            end
            alusf_pkg::OP_INCR, alusf_pkg::OP_DECR:
            begin
                data_next.reg_result = res;
                data_next.nz_value   = res;
                data_next.ctl.upd_nz = 1'b1;
            end
            alusf_pkg::OP_ASL, alusf_pkg::OP_ROL, alusf_pkg::OP_LSR, alusf_pkg::OP_ROR:
            begin
                data_next.nz_value   = rm;
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
            end
            alusf_pkg::OP_BIT:
            begin
                data_next.nz_value       = am;
                data_next.ctl.n_from_mem = 1'b1;
                data_next.ctl.v_new      = m[6];
                data_next.ctl.upd_nz     = 1'b1;
                data_next.ctl.upd_v      = 1'b1;
            end
            alusf_pkg::OP_SLO:
            begin
                data_next.reg_result = a | rm;
                data_next.nz_value   = a | rm;
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
            end
            alusf_pkg::OP_RLA:
            begin
                data_next.reg_result = a & rm;
                data_next.nz_value   = a & rm;
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
            end
            alusf_pkg::OP_SRE:
            begin
                data_next.reg_result = a ^ rm;
                data_next.nz_value   = a ^ rm;
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
            end
            alusf_pkg::OP_ANC:
            begin
                data_next.reg_result = am;
                data_next.nz_value   = am;
                data_next.ctl.c_new  = am[7];
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
            end
            alusf_pkg::OP_ALR:
            begin
                data_next.reg_result = {1'b0, am[7:1]};
                data_next.nz_value   = {1'b0, am[7:1]};
                data_next.ctl.c_new  = am[0];
                data_next.ctl.upd_nz = 1'b1;
                data_next.ctl.upd_c  = 1'b1;
            end
            default:
            begin
                data_next.reg_result = a;
            end
        endcase
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/alusf_flags.sv */
// Stage 3: status byte assembly and output register.
module alusf_flags
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  alusf_pkg::exec_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output alusf_pkg::out_item_t out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    alusf_pkg::out_item_t data_reg;
    alusf_pkg::out_item_t data_next;
    logic [7:0]           st;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        st = in_data.status_in;
        if (in_data.ctl.upd_nz)
        begin
            st[alusf_pkg::FLAG_N_BIT] = in_data.ctl.n_from_mem ? in_data.ctl.n_alt
                                                               : in_data.nz_value[7];
            st[alusf_pkg::FLAG_Z_BIT] = (in_data.nz_value == 8'h00);
        end
        if (in_data.ctl.upd_c)
        begin
            st[alusf_pkg::FLAG_C_BIT] = in_data.ctl.c_new;
        end
        if (in_data.ctl.upd_v)
        begin
            st[alusf_pkg::FLAG_V_BIT] = in_data.ctl.v_new;
        end
        data_next.reg_result = in_data.reg_result;
        data_next.mem_result = in_data.mem_result;
        data_next.status_out = st;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/alu_with_status_flags.sv */
// Top level of the 6502 binary-mode ALU: three-stage pipeline with status flags.
//
//  channel  | direction | payload
//  s_axis   | in        | operation, reg_value, mem_value, status_in
//  m_axis   | out       | reg_result, mem_result, status_out
//
//  One transaction per cycle while m_axis_tready is high; each stage registers it in turn.
//  Stages: operand modify, adder and logic, status assembly with output register.
//  Each stage holds its own valid bit and advances when empty or when the next stage takes it.
//  rst_n clears all valid bits asynchronously; payload registers are not reset.
//  With m_axis_tready low, up to three transactions are held and s_axis_tready drops.
module alu_with_status_flags
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // operation[4:0], reg_value[12:5], mem_value[20:13],
                                       // status_in[28:21], zero[31:29]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // reg_result[7:0], mem_result[15:8], status_out[23:16]
);

    alusf_pkg::in_item_t  in_item;
    alusf_pkg::prep_t     prep_data;
    alusf_pkg::exec_t     exec_data;
    alusf_pkg::out_item_t out_item;
    logic                 prep_valid;
    logic                 prep_ready;
    logic                 exec_valid;
    logic                 exec_ready;

    assign in_item.op        = alusf_pkg::op_t'(s_axis_tdata[4:0]);
    assign in_item.reg_value = s_axis_tdata[12:5];
    assign in_item.mem_value = s_axis_tdata[20:13];
    assign in_item.status_in = s_axis_tdata[28:21];

    alusf_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_item),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    alusf_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (exec_valid),
        .out_ready (exec_ready),
        .out_data  (exec_data)
    );

    alusf_flags u_flags
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exec_valid),
        .in_ready  (exec_ready),
        .in_data   (exec_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_item)
    );

    assign m_axis_tdata = {out_item.status_out, out_item.mem_result, out_item.reg_result};

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(exec_valid))
        else $error("output became valid without an execute-stage transaction");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (prep_valid && exec_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

endmodule

/* tb/tb.sv */
// Self-checking stream testbench for the 6502 binary-mode ALU with status flags.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] OP_CODE_MAX     = 5'd31;
    localparam int         RANDOM_ITEMS    = 1900;
    localparam int         CALM_ITEMS      = 300;
    localparam int         DRAIN_AT        = RANDOM_ITEMS / 2;
    localparam int         WATCHDOG_LIMIT  = 1000;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [4:0] op;
        logic [7:0] reg_v;
        logic [7:0] mem_v;
        logic [7:0] st_v;
        logic       pinned;
        logic [7:0] want_reg;
        logic [7:0] want_mem;
        logic [7:0] want_st;
    } stim_row_t;

    localparam int NUM_DIRECTED = 29;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{alusf_pkg::OP_ADC,  8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h02},
        '{alusf_pkg::OP_ADC,  8'hFF, 8'h01, 8'h00, 1'b1, 8'h00, 8'h01, 8'h03},
        '{alusf_pkg::OP_ADC,  8'h7F, 8'h01, 8'h00, 1'b1, 8'h80, 8'h01, 8'hC0},
        '{alusf_pkg::OP_SBC,  8'h00, 8'h01, 8'h01, 1'b1, 8'hFF, 8'h01, 8'h80},
        '{alusf_pkg::OP_SBC,  8'h80, 8'h01, 8'h01, 1'b1, 8'h7F, 8'h01, 8'h41},
        '{alusf_pkg::OP_AND,  8'hF0, 8'h0F, 8'hFF, 1'b1, 8'h00, 8'h0F, 8'h7F},
        '{alusf_pkg::OP_OR,   8'h80, 8'h01, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_XOR,  8'hFF, 8'h0F, 8'h3C, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_CMP,  8'h40, 8'h40, 8'h00, 1'b1, 8'h40, 8'h40, 8'h03},
        '{alusf_pkg::OP_CMP,  8'h00, 8'hFF, 8'hC3, 1'b1, 8'h00, 8'hFF, 8'h40},
        '{alusf_pkg::OP_INCM, 8'h12, 8'hFF, 8'h80, 1'b1, 8'h12, 8'h00, 8'h02},
        '{alusf_pkg::OP_DECM, 8'h34, 8'h00, 8'h00, 1'b1, 8'h34, 8'hFF, 8'h80},
        '{alusf_pkg::OP_INCR, 8'h7F, 8'h55, 8'h00, 1'b1, 8'h80, 8'h55, 8'h80},
        '{alusf_pkg::OP_DECR, 8'h01, 8'hAA, 8'h80, 1'b1, 8'h00, 8'hAA, 8'h02},
        '{alusf_pkg::OP_ASL,  8'h11, 8'h80, 8'h00, 1'b1, 8'h11, 8'h00, 8'h03},
        '{alusf_pkg::OP_ROL,  8'h00, 8'h7F, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_LSR,  8'h22, 8'h01, 8'h80, 1'b1, 8'h22, 8'h00, 8'h03},
        '{alusf_pkg::OP_ROR,  8'h00, 8'h00, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_BIT,  8'h0F, 8'hC0, 8'h00, 1'b1, 8'h0F, 8'hC0, 8'hC2},
        '{alusf_pkg::OP_SLO,  8'h01, 8'hC0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_RLA,  8'hFF, 8'h81, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_SRE,  8'h0F, 8'h03, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_RRA,  8'h7F, 8'h02, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_DCP,  8'h05, 8'h06, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_ISC,  8'h10, 8'h0F, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00},
        '{alusf_pkg::OP_ANC,  8'h80, 8'hFF, 8'h00, 1'b1, 8'h80, 8'hFF, 8'h81},
        '{alusf_pkg::OP_ALR,  8'h03, 8'h01, 8'h00, 1'b1, 8'h00, 8'h01, 8'h03},
        '{alusf_pkg::OP_PASS, 8'h5A, 8'hA5, 8'hFF, 1'b1, 8'h5A, 8'hA5, 8'hFF},
        '{OP_CODE_MAX,        8'hFF, 8'h00, 8'h24, 1'b1, 8'hFF, 8'h00, 8'h24}
    };

    localparam logic [7:0] CORNER_BYTES [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // operation, reg_value, mem_value, status_in, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;       // reg_result, mem_result, status_out

    alusf_pkg::out_item_t pending_results [$];
    int                   mismatches = 0;
    int                   results_checked = 0;
    int                   items_sent = 0;
    int                   quiet_cycles = 0;
    int                   stall_left = 0;
    bit                   calm = 1'b0;

    alu_with_status_flags dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] with_nz(input logic [7:0] st, input logic [7:0] v);
        st[alusf_pkg::FLAG_N_BIT] = v[7];
        st[alusf_pkg::FLAG_Z_BIT] = (v == 8'h00);
        return st;
    endfunction

    function automatic logic [7:0] add_byte(input logic [7:0] a, input logic [7:0] b,
                                            inout logic [7:0] st);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {8'h00, st[alusf_pkg::FLAG_C_BIT]};
        st = with_nz(st, sum[7:0]);
        st[alusf_pkg::FLAG_C_BIT] = sum[8];
        st[alusf_pkg::FLAG_V_BIT] = (a[7] ^ sum[7]) & (b[7] ^ sum[7]);
        return sum[7:0];
    endfunction

    function automatic void compare_byte(input logic [7:0] r, input logic [7:0] m,
                                         inout logic [7:0] st);
        st = with_nz(st, r - m);
        st[alusf_pkg::FLAG_C_BIT] = (r >= m);
    endfunction

    function automatic logic [7:0] shift_byte(input logic [4:0] kind, input logic [7:0] v,
                                              inout logic [7:0] st);
        logic       cin;
        logic [7:0] r;
        cin = st[alusf_pkg::FLAG_C_BIT];
        case (kind)
            alusf_pkg::OP_ASL: r = {v[6:0], 1'b0};
            alusf_pkg::OP_ROL: r = {v[6:0], cin};
            alusf_pkg::OP_LSR: r = {1'b0, v[7:1]};
            default:           r = {cin, v[7:1]};
        endcase
        st[alusf_pkg::FLAG_C_BIT] = (kind == alusf_pkg::OP_ASL || kind == alusf_pkg::OP_ROL)
                                    ? v[7] : v[0];
        st = with_nz(st, r);
        return r;
    endfunction

    function automatic alusf_pkg::out_item_t alu_outcome(input logic [4:0] op,
                                                         input logic [7:0] a,
                                                         input logic [7:0] m,
                                                         input logic [7:0] p);
        alusf_pkg::out_item_t res;
        logic [7:0]           ra;
        logic [7:0]           rm;
        logic [7:0]           st;
        ra = a;
        rm = m;
        st = p;
        case (op)
            alusf_pkg::OP_ADC: ra = add_byte(a, m, st);
            alusf_pkg::OP_SBC: ra = add_byte(a, ~m, st);
            alusf_pkg::OP_AND:
            begin
                ra = a & m;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_OR:
            begin
                ra = a | m;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_XOR:
            begin
                ra = a ^ m;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_CMP: compare_byte(a, m, st);
            alusf_pkg::OP_INCM:
            begin
                rm = m + 8'h01;
                st = with_nz(st, rm);
            end
            alusf_pkg::OP_DECM:
            begin
                rm = m - 8'h01;
                st = with_nz(st, rm);
            end
            alusf_pkg::OP_INCR:
            begin
                ra = a + 8'h01;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_DECR:
            begin
                ra = a - 8'h01;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_ASL, alusf_pkg::OP_ROL, alusf_pkg::OP_LSR, alusf_pkg::OP_ROR:
                rm = shift_byte(op, m, st);
            alusf_pkg::OP_BIT:
            begin
                st[alusf_pkg::FLAG_Z_BIT] = ((a & m) == 8'h00);
                st[alusf_pkg::FLAG_N_BIT] = m[7];
                st[alusf_pkg::FLAG_V_BIT] = m[6];
            end
            alusf_pkg::OP_SLO:
            begin
                rm = shift_byte(alusf_pkg::OP_ASL, m, st);
                ra = a | rm;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_RLA:
            begin
                rm = shift_byte(alusf_pkg::OP_ROL, m, st);
                ra = a & rm;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_SRE:
            begin
                rm = shift_byte(alusf_pkg::OP_LSR, m, st);
                ra = a ^ rm;
                st = with_nz(st, ra);
            end
            alusf_pkg::OP_RRA:
            begin
                rm = shift_byte(alusf_pkg::OP_ROR, m, st);
                ra = add_byte(a, rm, st);
            end
            alusf_pkg::OP_DCP:
            begin
                rm = m - 8'h01;
                compare_byte(a, rm, st);
            end
            alusf_pkg::OP_ISC:
            begin
                rm = m + 8'h01;
                ra = add_byte(a, ~rm, st);
            end
            alusf_pkg::OP_ANC:
            begin
                ra = a & m;
                st = with_nz(st, ra);
                st[alusf_pkg::FLAG_C_BIT] = ra[7];
            end
            alusf_pkg::OP_ALR:
            begin
                ra = a & m;
                st[alusf_pkg::FLAG_C_BIT] = ra[0];
                ra = ra >> 1;
                st = with_nz(st, ra);
            end
            default: ;
        endcase
        res.reg_result = ra;
        res.mem_result = rm;
        res.status_out = st;
        return res;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0)
            return CORNER_BYTES[$urandom_range(0, 4)];
        return 8'($urandom);
    endfunction

    // hold the transaction until it is taken; valid stays high for the caller
    task automatic send_item(input logic [4:0] op, input logic [7:0] a, input logic [7:0] m,
                             input logic [7:0] p, input alusf_pkg::out_item_t want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, p, m, a, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(want);
        items_sent++;
    endtask

    task automatic sender_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12))
            @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] %s mismatch: expected %02h, got %02h", $realtime, field,
                         want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        alusf_pkg::out_item_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] result %06h with no transaction outstanding",
                                 $realtime, m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("reg_result", want.reg_result, m_axis_tdata[7:0]);
                    check_field("mem_result", want.mem_result, m_axis_tdata[15:8]);
                    check_field("status_out", want.status_out, m_axis_tdata[23:16]);
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        alusf_pkg::out_item_t want;
        logic [4:0]           op;
        logic [7:0]           a;
        logic [7:0]           m;
        logic [7:0]           p;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (i != 0 && $urandom_range(0, 3) == 0)
                sender_gap();
            if (DIRECTED[i].pinned)
            begin
                want.reg_result = DIRECTED[i].want_reg;
                want.mem_result = DIRECTED[i].want_mem;
                want.status_out = DIRECTED[i].want_st;
            end
            else
                want = alu_outcome(DIRECTED[i].op, DIRECTED[i].reg_v, DIRECTED[i].mem_v,
                                   DIRECTED[i].st_v);
            send_item(DIRECTED[i].op, DIRECTED[i].reg_v, DIRECTED[i].mem_v,
                      DIRECTED[i].st_v, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            // drain the pipeline completely once before continuing
            if (n == DRAIN_AT)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
                sender_gap();
            if ($urandom_range(0, 15) == 0)
                op = 5'($urandom_range(int'(alusf_pkg::OP_PASS) + 1, int'(OP_CODE_MAX)));
            else
                op = 5'($urandom_range(0, int'(alusf_pkg::OP_PASS)));
            a = pick_byte();
            m = pick_byte();
            p = 8'($urandom);
            send_item(op, a, m, p, alu_outcome(op, a, m, p));
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d transactions (%0d directed corner cases, the rest random over all",
                 items_sent, NUM_DIRECTED);
        $display("operation codes with edge-biased operands); %0d results checked, %0d errors",
                 results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
